// File: src/gillespie_reaction_step_top_macros.svh
// Assertion macros used by the checker file.
`ifndef GILLESPIE_REACTION_STEP_TOP_MACROS_SVH
`define GILLESPIE_REACTION_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grs check failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grs check failed");

`endif

// File: src/grs_pkg.sv
package grs_pkg;

  localparam int CountW     = 16;
  localparam int NumRx      = 17;
  localparam int RxIdxW     = 5;
  localparam int HazW       = 56;
  localparam int TotW       = 61;
  localparam int DivW       = 62;
  localparam int DtW        = 48;
  localparam int ClkW       = 56;
  localparam int RateW      = 48;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 32;
  localparam int RateFracW  = 24;

  localparam logic [31:0]     Ln2Q32    = 32'd2977044472;
  localparam logic [HazW-1:0] HazMax    = {HazW{1'b1}};
  localparam logic [DtW-1:0]  DtMax     = {DtW{1'b1}};
  localparam logic [ClkW-1:0] ClkMax    = {ClkW{1'b1}};
  localparam logic [31:0]     ProtReset = 32'h0100_0000;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FUSION  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FISSION = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEGRADE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROTECT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAIN    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_TARGET  = 3'd5;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXTINCT   = 3'd1,
    ST_ZERO_RATE = 3'd2,
    ST_NEGATIVE  = 3'd3,
    ST_SATURATED = 3'd4
  } status_e;

  typedef enum logic [1:0] {SP_WS, SP_WF, SP_MS, SP_MF} species_e;

  // second factor of the count product
  typedef enum logic [1:0] {YK_ONE, YK_PAIR, YK_SPECIES} ykind_e;

  typedef enum logic [2:0] {RT_FUSION, RT_FISSION, RT_REP, RT_DEGF, RT_DEG} rate_e;

  // count deltas, two's complement
  localparam logic [2:0] D_M2 = 3'b110;
  localparam logic [2:0] D_M1 = 3'b111;
  localparam logic [2:0] D_00 = 3'b000;
  localparam logic [2:0] D_P1 = 3'b001;
  localparam logic [2:0] D_P2 = 3'b010;

  typedef struct packed {
    species_e   x;
    ykind_e     yk;
    species_e   y;
    rate_e      rate;
    logic [2:0] d_ws;
    logic [2:0] d_wf;
    logic [2:0] d_ms;
    logic [2:0] d_mf;
  } rx_info_t;

  localparam rx_info_t RX_TAB [NumRx] = '{
    '{SP_WS, YK_PAIR,    SP_WS, RT_FUSION,  D_M2, D_P2, D_00, D_00},
    '{SP_MS, YK_PAIR,    SP_MS, RT_FUSION,  D_00, D_00, D_M2, D_P2},
    '{SP_WF, YK_SPECIES, SP_WS, RT_FUSION,  D_M1, D_P1, D_00, D_00},
    '{SP_MF, YK_SPECIES, SP_MS, RT_FUSION,  D_00, D_00, D_M1, D_P1},
    '{SP_WF, YK_ONE,     SP_WF, RT_FISSION, D_P1, D_M1, D_00, D_00},
    '{SP_MF, YK_ONE,     SP_MF, RT_FISSION, D_00, D_00, D_P1, D_M1},
    '{SP_WF, YK_ONE,     SP_WF, RT_REP,     D_00, D_P1, D_00, D_00},
    '{SP_MF, YK_ONE,     SP_MF, RT_REP,     D_00, D_00, D_00, D_P1},
    '{SP_WS, YK_ONE,     SP_WS, RT_REP,     D_M1, D_P2, D_00, D_00},
    '{SP_MS, YK_ONE,     SP_MS, RT_REP,     D_00, D_00, D_M1, D_P2},
    '{SP_WF, YK_ONE,     SP_WF, RT_DEGF,    D_00, D_M1, D_00, D_00},
    '{SP_MF, YK_ONE,     SP_MF, RT_DEGF,    D_00, D_00, D_00, D_M1},
    '{SP_WS, YK_ONE,     SP_WS, RT_DEG,     D_M1, D_00, D_00, D_00},
    '{SP_MS, YK_ONE,     SP_MS, RT_DEG,     D_00, D_00, D_M1, D_00},
    '{SP_WF, YK_SPECIES, SP_MS, RT_FUSION,  D_00, D_00, D_M1, D_P1},
    '{SP_MF, YK_SPECIES, SP_WS, RT_FUSION,  D_M1, D_P1, D_00, D_00},
    '{SP_WS, YK_SPECIES, SP_MS, RT_FUSION,  D_M1, D_P1, D_M1, D_P1}
  };

endpackage

// File: src/grs_mul.sv
module grs_mul
  import grs_pkg::*;
(
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  // product is registered and lands in the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= {32'b0, a_i} * {32'b0, b_i};
  end

  assign p_o = p_q;

endmodule

// File: src/gillespie_reaction_step_top.sv
// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_data_i
// in        in         in_valid_i / in_ready_o    func_i, load_*_i, time_draw_i, choice_draw_i
// out       out        out_valid_o / out_ready_i  status_o, reaction_o, counts, time_step_o,
//                                                 elapsed_time_o
//
// A load transfer or a step on an empty population goes from idle straight to the done state.
// A full step runs in sequence on the single shared 32x32 multiplier: a hazard pass over
// 17 hazards, normalize shifts and 32 squaring steps for the logarithm, a restoring
// division over 62 quotient bits, and a hazard scan that reads one entry at a time.
// Input ready is high only in idle; one item is in flight at a time.
// A result waits in the output register while the next item is taken in; a stalled
// output delays only the end of the following item.
// Reset is asynchronous, active low; it clears counts, time and config to reset values.
module gillespie_reaction_step_top
  import grs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [15:0]          load_wild_single_i,
  input  logic [15:0]          load_wild_fused_i,
  input  logic [15:0]          load_mutant_single_i,
  input  logic [15:0]          load_mutant_fused_i,
  input  logic [31:0]          time_draw_i,
  input  logic [31:0]          choice_draw_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [4:0]           reaction_o,
  output logic [15:0]          wild_single_o,
  output logic [15:0]          wild_fused_o,
  output logic [15:0]          mutant_single_o,
  output logic [15:0]          mutant_fused_o,
  output logic [47:0]          time_step_o,
  output logic [55:0]          elapsed_time_o
);

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_REP_MUL  = 21'h000002,
    S_DEG_MUL  = 21'h000004,
    S_CNT_MUL  = 21'h000008,
    S_RLO_MUL  = 21'h000010,
    S_RHI_MUL  = 21'h000020,
    S_HAZ_WR   = 21'h000040,
    S_NORM     = 21'h000080,
    S_SQ_MUL   = 21'h000100,
    S_SQ_UPD   = 21'h000200,
    S_LN_HI    = 21'h000400,
    S_LN_LO    = 21'h000800,
    S_LN_SUM   = 21'h001000,
    S_DIV      = 21'h002000,
    S_THR_LO   = 21'h004000,
    S_THR_HI   = 21'h008000,
    S_THR_SUM  = 21'h010000,
    S_SCAN_RD  = 21'h020000,
    S_SCAN_CMP = 21'h040000,
    S_APPLY    = 21'h080000,
    S_DONE     = 21'h100000
  } state_e;

  localparam logic [RxIdxW-1:0] LastRx  = RxIdxW'(NumRx - 1);
  localparam logic [4:0]        SqLast  = 5'd31;
  localparam logic [5:0]        DivLast = 6'(DivW - 1);

  state_e state_q, state_d;

  // configuration
  logic [31:0] fusion_q, fission_q, deg_q, prot_q, gain_q;
  logic [23:0] target_q;

  // population state
  logic [CountW-1:0] ws_q, wf_q, ms_q, mf_q;
  logic [ClkW-1:0]   clock_q;

  // per-step working registers
  logic [31:0]       td_q, cd_q;
  logic [RateW-1:0]  rep_q;
  logic [39:0]       degf_q;
  logic [RxIdxW-1:0] hidx_q, sidx_q;
  logic [31:0]       cnt_q;
  logic [63:0]       lo_q;
  logic [TotW-1:0]   total_q, thr_q, cum_q;
  logic [HazW-1:0]   haz_mem [NumRx];
  logic [HazW-1:0]   rd_q;
  logic [32:0]       f_q;
  logic [5:0]        k_q;
  logic [31:0]       lf_q;
  logic [4:0]        it_q;
  logic [37:0]       l2_q, ehi_q;
  logic [DivW-1:0]   num_q, rem_q, quo_q;
  logic [5:0]        dcnt_q;
  logic [DtW-1:0]    dt_q;

  // result staging and output register
  status_e           res_status_q;
  logic [RxIdxW-1:0] res_rx_q;
  logic [DtW-1:0]    res_dt_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [4:0]        out_rx_q;
  logic [15:0]       out_ws_q, out_wf_q, out_ms_q, out_mf_q;
  logic [47:0]       out_dt_q;
  logic [55:0]       out_clk_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  grs_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  function automatic logic [CountW-1:0] sel_cnt(
    input species_e s,
    input logic [CountW-1:0] ws,
    input logic [CountW-1:0] wf,
    input logic [CountW-1:0] ms,
    input logic [CountW-1:0] mf
  );
    logic [CountW-1:0] r;
    case (s)
      SP_WS:   r = ws;
      SP_WF:   r = wf;
      SP_MS:   r = ms;
      SP_MF:   r = mf;
      default: r = ws;
    endcase
    return r;
  endfunction

  function automatic logic [CountW+1:0] add_delta(
    input logic [CountW-1:0] c,
    input logic [2:0] d
  );
    return {2'b00, c} + {{(CountW-1){d[2]}}, d};
  endfunction

  function automatic logic [CountW-1:0] clip_cnt(input logic [CountW+1:0] v);
    return v[CountW] ? {CountW{1'b1}} : v[CountW-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Combinational datapath
  // ---------------------------------------------------------------------------
  rx_info_t          info_h, info_p;
  logic [CountW-1:0] x_cnt, y_cnt;
  logic [RateW-1:0]  rate_sel;
  logic [24:0]       wt;
  logic [24:0]       tdiff;
  logic [31:0]       c_val;
  logic [47:0]       hi_prod;
  logic [64:0]       haz_sum;
  logic [HazW-1:0]   haz_val;
  logic [TotW-1:0]   total_n;
  logic [32:0]       sq_val;
  logic [37:0]       l2_c;
  logic [37:0]       e_val;
  logic [DivW-1:0]   rem_sh, rem_sub, rem_n, quo_n;
  logic              div_ge;
  logic [61:0]       thr_c;
  logic [TotW-1:0]   cum_n;
  logic              scan_hit;
  logic [CountW+1:0] n_ws, n_wf, n_ms, n_mf;
  logic              any_neg, any_sat;
  logic [ClkW:0]     clk_sum;
  logic              in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  assign info_h = RX_TAB[hidx_q];
  assign info_p = RX_TAB[res_rx_q];

  assign x_cnt = sel_cnt(info_h.x, ws_q, wf_q, ms_q, mf_q);

  always_comb begin
    case (info_h.yk)
      YK_ONE:     y_cnt = CountW'(1);
      YK_PAIR:    y_cnt = (x_cnt == '0) ? '0 : x_cnt - CountW'(1);
      YK_SPECIES: y_cnt = sel_cnt(info_h.y, ws_q, wf_q, ms_q, mf_q);
      default:    y_cnt = '0;
    endcase
  end

  always_comb begin
    case (info_h.rate)
      RT_FUSION:  rate_sel = {16'b0, fusion_q};
      RT_FISSION: rate_sel = {16'b0, fission_q};
      RT_REP:     rate_sel = rep_q;
      RT_DEGF:    rate_sel = {8'b0, degf_q};
      RT_DEG:     rate_sel = {16'b0, deg_q};
      default:    rate_sel = '0;
    endcase
  end

  // replication drive: zero when the wild population is at or above target
  assign wt    = {({1'b0, ws_q} + {1'b0, wf_q}), 8'b0};
  assign tdiff = ({1'b0, target_q} > wt) ? ({1'b0, target_q} - wt) : '0;

  // count product, halved for same-species pairs
  assign c_val = (info_h.yk == YK_PAIR) ? mul_p[32:1] : mul_p[31:0];

  // hazard = count product * rate, clamped to the hazard width
  assign hi_prod = mul_p[47:0];
  assign haz_sum = {1'b0, lo_q} + {1'b0, hi_prod[23:0], 32'b0};
  assign haz_val = ((hi_prod[47:24] != '0) || (haz_sum[64:HazW] != '0))
                   ? HazMax : haz_sum[HazW-1:0];
  assign total_n = total_q + TotW'(haz_val);

  // squaring step of the log2 by repeated squaring
  assign sq_val = mul_p[63:31];

  assign l2_c  = {(6'd32 - k_q), 32'b0} - {6'b0, lf_q};
  assign e_val = ehi_q + {6'b0, mul_p[63:32]};

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_q[DivW-2:0], num_q[DivW-1]};
  assign div_ge  = (rem_sh >= {1'b0, total_q});
  assign rem_sub = rem_sh - {1'b0, total_q};
  assign rem_n   = div_ge ? rem_sub : rem_sh;
  assign quo_n   = {quo_q[DivW-2:0], div_ge};

  assign thr_c = mul_p[61:0] + {30'b0, lo_q[63:32]};

  assign cum_n    = cum_q + TotW'(rd_q);
  assign scan_hit = (cum_n > thr_q) || (sidx_q == LastRx);

  assign n_ws    = add_delta(ws_q, info_p.d_ws);
  assign n_wf    = add_delta(wf_q, info_p.d_wf);
  assign n_ms    = add_delta(ms_q, info_p.d_ms);
  assign n_mf    = add_delta(mf_q, info_p.d_mf);
  assign any_neg = n_ws[CountW+1] | n_wf[CountW+1] | n_ms[CountW+1] | n_mf[CountW+1];
  assign any_sat = n_ws[CountW] | n_wf[CountW] | n_ms[CountW] | n_mf[CountW];
  assign clk_sum = {1'b0, clock_q} + {{(ClkW-DtW+1){1'b0}}, dt_q};

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_REP_MUL: begin
        mul_a = gain_q;
        mul_b = {7'b0, tdiff};
      end
      S_DEG_MUL: begin
        mul_a = prot_q;
        mul_b = deg_q;
      end
      S_CNT_MUL: begin
        mul_a = 32'(x_cnt);
        mul_b = 32'(y_cnt);
      end
      S_RLO_MUL: begin
        mul_a = c_val;
        mul_b = rate_sel[31:0];
      end
      S_RHI_MUL: begin
        mul_a = cnt_q;
        mul_b = {16'b0, rate_sel[47:32]};
      end
      S_SQ_MUL: begin
        mul_a = f_q[31:0];
        mul_b = f_q[31:0];
      end
      S_LN_HI: begin
        mul_a = {26'b0, l2_c[37:32]};
        mul_b = Ln2Q32;
      end
      S_LN_LO: begin
        mul_a = l2_q[31:0];
        mul_b = Ln2Q32;
      end
      S_THR_LO: begin
        mul_a = cd_q;
        mul_b = total_q[31:0];
      end
      S_THR_HI: begin
        mul_a = cd_q;
        mul_b = {3'b0, total_q[TotW-1:32]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!func_i || ((ws_q | wf_q | ms_q | mf_q) == '0)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_REP_MUL;
          end
        end
      end
      S_REP_MUL: state_d = S_DEG_MUL;
      S_DEG_MUL: state_d = S_CNT_MUL;
      S_CNT_MUL: state_d = S_RLO_MUL;
      S_RLO_MUL: state_d = S_RHI_MUL;
      S_RHI_MUL: state_d = S_HAZ_WR;
      S_HAZ_WR: begin
        if (hidx_q != LastRx) begin
          state_d = S_CNT_MUL;
        end else if (total_n == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (f_q[32] || f_q[31]) begin
          state_d = S_SQ_MUL;
        end
      end
      S_SQ_MUL: state_d = S_SQ_UPD;
      S_SQ_UPD: state_d = (it_q == SqLast) ? S_LN_HI : S_SQ_MUL;
      S_LN_HI:  state_d = S_LN_LO;
      S_LN_LO:  state_d = S_LN_SUM;
      S_LN_SUM: state_d = S_DIV;
      S_DIV:    state_d = (dcnt_q == '0) ? S_THR_LO : S_DIV;
      S_THR_LO: state_d = S_THR_HI;
      S_THR_HI: state_d = S_THR_SUM;
      S_THR_SUM: state_d = S_SCAN_RD;
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: state_d = scan_hit ? S_APPLY : S_SCAN_RD;
      S_APPLY:  state_d = S_DONE;
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state, configuration and population
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fusion_q    <= '0;
      fission_q   <= '0;
      deg_q       <= '0;
      prot_q      <= ProtReset;
      gain_q      <= '0;
      target_q    <= '0;
      ws_q        <= '0;
      wf_q        <= '0;
      ms_q        <= '0;
      mf_q        <= '0;
      clock_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // config writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FUSION:  fusion_q  <= cfg_data_i;
          CFG_FISSION: fission_q <= cfg_data_i;
          CFG_DEGRADE: deg_q     <= cfg_data_i;
          CFG_PROTECT: prot_q    <= cfg_data_i;
          CFG_GAIN:    gain_q    <= cfg_data_i;
          CFG_TARGET:  target_q  <= cfg_data_i[23:0];
          default: ;
        endcase
      end

      // load: take the new counts and restart time
      if (in_acc && !func_i) begin
        ws_q    <= load_wild_single_i[CountW-1:0];
        wf_q    <= load_wild_fused_i[CountW-1:0];
        ms_q    <= load_mutant_single_i[CountW-1:0];
        mf_q    <= load_mutant_fused_i[CountW-1:0];
        clock_q <= '0;
      end

      // fire the picked reaction unless a count would go negative
      if (state_q == S_APPLY && !any_neg) begin
        ws_q    <= clip_cnt(n_ws);
        wf_q    <= clip_cnt(n_wf);
        ms_q    <= clip_cnt(n_ms);
        mf_q    <= clip_cnt(n_mf);
        clock_q <= clk_sum[ClkW] ? ClkMax : clk_sum[ClkW-1:0];
      end

      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        td_q    <= time_draw_i;
        cd_q    <= choice_draw_i;
        hidx_q  <= '0;
        total_q <= '0;
        res_rx_q <= '0;
        res_dt_q <= '0;
        res_status_q <= (func_i && ((ws_q | wf_q | ms_q | mf_q) == '0)) ? ST_EXTINCT : ST_OK;
      end
      S_DEG_MUL: rep_q <= mul_p[55:8];
      S_CNT_MUL: begin
        if (hidx_q == '0) begin
          degf_q <= mul_p[63:RateFracW];
        end
      end
      S_RLO_MUL: cnt_q <= c_val;
      S_RHI_MUL: lo_q <= mul_p;
      S_HAZ_WR: begin
        total_q <= total_n;
        hidx_q  <= hidx_q + RxIdxW'(1);
        f_q     <= {1'b0, td_q} + 33'd1;
        k_q     <= 6'd31;
        lf_q    <= '0;
        it_q    <= '0;
        if (hidx_q == LastRx && total_n == '0) begin
          res_status_q <= ST_ZERO_RATE;
        end
      end
      S_NORM: begin
        if (f_q[32]) begin
          f_q <= {1'b0, f_q[32:1]};
          k_q <= 6'd32;
        end else if (!f_q[31]) begin
          f_q <= {f_q[31:0], 1'b0};
          k_q <= k_q - 6'd1;
        end
      end
      S_SQ_UPD: begin
        lf_q <= {lf_q[30:0], sq_val[32]};
        f_q  <= sq_val[32] ? {1'b0, sq_val[32:1]} : sq_val;
        it_q <= it_q + 5'd1;
      end
      S_LN_HI: l2_q <= l2_c;
      S_LN_LO: ehi_q <= mul_p[37:0];
      S_LN_SUM: begin
        num_q  <= {e_val, 24'b0};
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= DivLast;
      end
      S_DIV: begin
        num_q  <= {num_q[DivW-2:0], 1'b0};
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        dcnt_q <= dcnt_q - 6'd1;
        if (dcnt_q == '0) begin
          dt_q <= (quo_n[DivW-1:DtW] != '0) ? DtMax : quo_n[DtW-1:0];
        end
      end
      S_THR_HI: lo_q <= mul_p;
      S_THR_SUM: begin
        thr_q  <= thr_c[TotW-1:0];
        sidx_q <= '0;
        cum_q  <= '0;
      end
      S_SCAN_CMP: begin
        cum_q <= cum_n;
        if (scan_hit) begin
          res_rx_q <= sidx_q;
        end else begin
          sidx_q <= sidx_q + RxIdxW'(1);
        end
      end
      S_APPLY: begin
        if (any_neg) begin
          res_status_q <= ST_NEGATIVE;
          res_dt_q     <= '0;
        end else begin
          res_status_q <= any_sat ? ST_SATURATED : ST_OK;
          res_dt_q     <= dt_q;
        end
      end
      default: ;
    endcase
  end

  // hazard store: written during the hazard pass, read back during the scan
  always_ff @(posedge clk_i) begin
    if (state_q == S_HAZ_WR) begin
      haz_mem[hidx_q] <= haz_val;
    end
    if (state_q == S_SCAN_RD) begin
      rd_q <= haz_mem[sidx_q];
    end
  end

  // output register: capture the finished result when the slot is free
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
      out_status_q <= res_status_q;
      out_rx_q     <= res_rx_q;
      out_ws_q     <= ws_q;
      out_wf_q     <= wf_q;
      out_ms_q     <= ms_q;
      out_mf_q     <= mf_q;
      out_dt_q     <= res_dt_q;
      out_clk_q    <= clock_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign reaction_o      = out_rx_q;
  assign wild_single_o   = out_ws_q;
  assign wild_fused_o    = out_wf_q;
  assign mutant_single_o = out_ms_q;
  assign mutant_fused_o  = out_mf_q;
  assign time_step_o     = out_dt_q;
  assign elapsed_time_o  = out_clk_q;

endmodule

// File: src/grs_checker.sv
`include "gillespie_reaction_step_top_macros.svh"

module grs_checker
  import grs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [4:0]  reaction_o,
  input logic [47:0] time_step_o
);

  // a held result keeps its payload
  `GRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o) && $stable(reaction_o) && $stable(time_step_o))

  // one item in flight: ready drops after every input transfer
  `GRS_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // no event fired: no reaction index and no time advance
  `GRS_ASSERT_NOW(a_idle_result, clk_i, rst_ni, out_valid_o && (status_o == ST_EXTINCT || status_o == ST_ZERO_RATE), reaction_o == '0 && time_step_o == '0)

  // a rejected event never advances time
  `GRS_ASSERT_NOW(a_neg_no_time, clk_i, rst_ni, out_valid_o && status_o == ST_NEGATIVE, time_step_o == '0)

endmodule

bind gillespie_reaction_step_top grs_checker u_grs_checker (.*);
